// ===== design/srec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record parser package
// Shared types and constants for the S-record line parser and checker.
// ----------------------------------------------------------------------------
package srec_pkg;

	localparam int POS_W = 10;
	localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
	localparam logic [7:0] CHAR_S = 8'h53;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_SYNTAX   = 2'd2,
		ST_COUNT    = 2'd3
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_RECORD = 1'b1
	} kind_t;

	// One classified character as it travels through the queue
	typedef struct packed {
		logic       eol;
		logic       is_s;
		logic       hex_ok;
		logic [3:0] nibble;
		logic       type_bad;
		logic [2:0] addr_bytes;
	} item_t;

endpackage

// ===== design/srec_line_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record line parser and checker
// Parses one S-record line a character at a time, emits decoded data bytes
// and a closing status record with type, address and byte count.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | receive   | in_valid/in_stall  | char_in, end_of_line
//  out     | send      | out_valid/out_stall| kind, data_byte, status,
//          |           |                    | record_type, address, byte_count
//
//  One character per cycle, sustained while out_stall is low. A character
//  is written into the queue at its transfer; the back end decodes it once
//  it reaches the queue head and is popped, and its result, if any, is
//  registered in the output register. The back end's decode sets the rate.
//  arst_n clears the queue, the parser state and the output valid.
//  out_stall holds the result register; the queue (QUEUE_DEPTH entries)
//  absorbs input until it fills, and then in_stall rises.
//
module srec_line_parser_checker #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  status,
	output logic [3:0]  record_type,
	output logic [31:0] address,
	output logic [7:0]  byte_count
);

	srec_pkg::item_t front_item;
	srec_pkg::item_t back_item;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_valid;

	// classify each character at its transfer
	srec_front u_front (
		.in_valid    (in_valid),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.q_full      (q_full),
		.in_stall    (in_stall),
		.push        (push),
		.item        (front_item)
	);

	// decouple input acceptance from result back-pressure
	srec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (front_item),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_item  (back_item),
		.full     (q_full)
	);

	// advance the parser and register the result
	srec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (back_item),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.status      (status),
		.record_type (record_type),
		.address     (address),
		.byte_count  (byte_count)
	);

endmodule

// ===== design/srec_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record front end
// Accepts characters and classifies them: hex value, 'S' mark, type digit.
// ----------------------------------------------------------------------------
module srec_front (
	input  logic           in_valid,
	input  logic [7:0]     char_in,
	input  logic           end_of_line,
	input  logic           q_full,
	output logic           in_stall,
	output logic           push,
	output srec_pkg::item_t item
);

	logic [3:0] nib;
	logic       hex_ok;

	always_comb begin
		nib    = 4'd0;
		hex_ok = 1'b0;
		case (char_in) inside
			[8'h30:8'h39]: begin
				nib    = char_in[3:0];
				hex_ok = 1'b1;
			end
			[8'h41:8'h46]: begin
				nib    = char_in[3:0] + 4'd9;
				hex_ok = 1'b1;
			end
			default: begin
				nib    = 4'd0;
				hex_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		item.eol      = end_of_line;
		item.is_s     = (char_in == srec_pkg::CHAR_S);
		item.hex_ok   = hex_ok;
		item.nibble   = nib;
		item.type_bad = (nib > 4'd9) || (nib == 4'd4);
		case (nib) inside
			4'd2, 4'd6, 4'd8: item.addr_bytes = 3'd3;
			4'd3, 4'd7:       item.addr_bytes = 3'd4;
			default:          item.addr_bytes = 3'd2;
		endcase
	end

	// hold off the sender while the queue is full
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

// ===== design/srec_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record item queue
// Short FIFO of classified characters between front and back end.
// ----------------------------------------------------------------------------
module srec_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srec_pkg::item_t wr_item,
	input  logic            pop,
	output logic            rd_valid,
	output srec_pkg::item_t rd_item,
	output logic            full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	srec_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rd_valid = (count_q != '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/srec_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record back end
// Field decode, checksum and error tracking; registered result output.
// ----------------------------------------------------------------------------
module srec_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  srec_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            kind,
	output logic [7:0]      data_byte,
	output logic [1:0]      status,
	output logic [3:0]      record_type,
	output logic [31:0]     address,
	output logic [7:0]      byte_count
);

	typedef enum logic [1:0] {
		RG_COUNT = 2'd0,
		RG_ADDR  = 2'd1,
		RG_DATA  = 2'd2,
		RG_CHK   = 2'd3
	} region_t;

	// parser state
	logic [srec_pkg::POS_W-1:0] pos_q;
	logic [3:0]                 type_q;
	logic [2:0]                 addr_bytes_q;
	logic [7:0]                 count_q;
	logic [31:0]                addr_q;
	logic [7:0]                 sum_q;
	logic [3:0]                 high_q;
	srec_pkg::status_t          err_q;

	// result register
	logic              out_valid_q;
	srec_pkg::kind_t   kind_q;
	logic [7:0]        data_q;
	srec_pkg::status_t status_q;
	logic [3:0]        type_out_q;
	logic [31:0]       addr_out_q;
	logic [7:0]        count_out_q;

	logic [3:0]                 type_n;
	logic [2:0]                 addr_bytes_n;
	logic [7:0]                 count_n;
	logic [31:0]                addr_n;
	logic [7:0]                 sum_n;
	logic [3:0]                 high_n;
	srec_pkg::status_t          err_n;
	srec_pkg::status_t          eol_status;
	logic [srec_pkg::POS_W-1:0] h;
	logic [srec_pkg::POS_W-2:0] b;
	logic [srec_pkg::POS_W-1:0] last;
	logic [srec_pkg::POS_W-1:0] last_eol;
	logic [7:0]                 byte_val;
	region_t                    region;
	logic                       emit;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		type_n       = type_q;
		addr_bytes_n = addr_bytes_q;
		count_n      = count_q;
		addr_n       = addr_q;
		sum_n        = sum_q;
		high_n       = high_q;
		err_n        = err_q;
		emit         = 1'b0;
		h            = pos_q - 10'd2;
		b            = h[srec_pkg::POS_W-1:1];
		last         = {1'b0, count_q, 1'b0} + 10'd3;
		byte_val     = {high_q, q_item.nibble};

		if (b == '0) begin
			region = RG_COUNT;
		end else if (b <= {6'd0, addr_bytes_q}) begin
			region = RG_ADDR;
		end else if (b < {1'b0, count_q}) begin
			region = RG_DATA;
		end else begin
			region = RG_CHK;
		end

		if (err_q == srec_pkg::ST_OK) begin
			if (pos_q == 10'd0) begin
				if (!q_item.is_s) err_n = srec_pkg::ST_SYNTAX;
			end else if (pos_q == 10'd1) begin
				if (!q_item.hex_ok) begin
					type_n = 4'd0;
					err_n  = srec_pkg::ST_SYNTAX;
				end else begin
					type_n = q_item.nibble;
					if (q_item.type_bad) err_n = srec_pkg::ST_SYNTAX;
					else addr_bytes_n = q_item.addr_bytes;
				end
			end else if (!(b != '0 && pos_q > last)) begin
				if (!q_item.hex_ok) begin
					err_n = (region == RG_DATA) ? srec_pkg::ST_COUNT : srec_pkg::ST_SYNTAX;
				end else begin
					if (region == RG_ADDR) addr_n = {addr_q[27:0], q_item.nibble};
					if (!pos_q[0]) begin
						high_n = q_item.nibble;
					end else if (region == RG_CHK) begin
						if (~sum_q != byte_val) err_n = srec_pkg::ST_CHECKSUM;
					end else begin
						sum_n = sum_q + byte_val;
						if (region == RG_COUNT) begin
							count_n = byte_val;
							if (byte_val < {5'd0, addr_bytes_q} + 8'd1) begin
								err_n = srec_pkg::ST_COUNT;
							end
						end else if (region == RG_DATA) begin
							emit = 1'b1;
						end
					end
				end
			end
		end

		// a line that stops before the first checksum character is short
		last_eol = {1'b0, count_n, 1'b0} + 10'd3;
		if (err_n == srec_pkg::ST_OK && !(pos_q >= 10'd3 && pos_q >= last_eol)) begin
			eol_status = srec_pkg::ST_COUNT;
		end else begin
			eol_status = err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			type_q       <= '0;
			addr_bytes_q <= '0;
			count_q      <= '0;
			addr_q       <= '0;
			sum_q        <= '0;
			high_q       <= '0;
			err_q        <= srec_pkg::ST_OK;
		end else if (q_pop) begin
			if (q_item.eol) begin
				pos_q        <= '0;
				type_q       <= '0;
				addr_bytes_q <= '0;
				count_q      <= '0;
				addr_q       <= '0;
				sum_q        <= '0;
				high_q       <= '0;
				err_q        <= srec_pkg::ST_OK;
			end else begin
				if (pos_q != srec_pkg::POS_MAX) pos_q <= pos_q + 10'd1;
				type_q       <= type_n;
				addr_bytes_q <= addr_bytes_n;
				count_q      <= count_n;
				addr_q       <= addr_n;
				sum_q        <= sum_n;
				high_q       <= high_n;
				err_q        <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= q_item.eol || emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_item.eol) begin
				kind_q      <= srec_pkg::KIND_RECORD;
				data_q      <= 8'd0;
				status_q    <= eol_status;
				type_out_q  <= type_n;
				addr_out_q  <= addr_n;
				count_out_q <= count_n;
			end else begin
				kind_q      <= srec_pkg::KIND_DATA;
				data_q      <= byte_val;
				status_q    <= srec_pkg::ST_OK;
				type_out_q  <= 4'd0;
				addr_out_q  <= 32'd0;
				count_out_q <= 8'd0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign status      = status_q;
	assign record_type = type_out_q;
	assign address     = addr_out_q;
	assign byte_count  = count_out_q;

endmodule

// ===== design/srec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-record parser port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module srec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [7:0]  data_byte,
	input logic [1:0]  status,
	input logic [3:0]  record_type,
	input logic [31:0] address,
	input logic [7:0]  byte_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(status) && $stable(address))
		else $error("result changed while stalled");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == srec_pkg::KIND_DATA |->
			status == srec_pkg::ST_OK && record_type == 4'd0
			&& address == 32'd0 && byte_count == 8'd0)
		else $error("data transfer carries record fields");

	a_record_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == srec_pkg::KIND_RECORD |-> data_byte == 8'd0)
		else $error("record transfer carries a data byte");

	a_ok_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == srec_pkg::KIND_RECORD && status == srec_pkg::ST_OK |->
			record_type <= 4'd9 && record_type != 4'd4 && byte_count >= 8'd3)
		else $error("good record with bad type or count");

endmodule

bind srec_line_parser_checker srec_checker u_srec_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.data_byte   (data_byte),
	.status      (status),
	.record_type (record_type),
	.address     (address),
	.byte_count  (byte_count)
);
